>>> sv/te2f_pkg.sv
package te2f_pkg;

  localparam int unsigned OpWidth   = 4;
  localparam int unsigned RawWidth  = 64;
  localparam int unsigned Fp32Width = 32;
  localparam int unsigned PosWidth  = 6;

  typedef enum logic [OpWidth-1:0] {
    OP_F32  = 4'd0,
    OP_F16  = 4'd1,
    OP_BF16 = 4'd2,
    OP_I64  = 4'd3,
    OP_I32  = 4'd4,
    OP_I16  = 4'd5,
    OP_I8   = 4'd6,
    OP_U8   = 4'd7,
    OP_BOOL = 4'd8,
    OP_E4M3 = 4'd9,
    OP_E5M2 = 4'd10
  } op_e;

  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] InfBits  = 32'h7F80_0000;
  localparam logic [31:0] OneBits  = 32'h3F80_0000;

  // Stage 1 to stage 2: either a finished word or a magnitude to normalize.
  typedef struct packed {
    logic        done;
    logic [31:0] word;
    logic        sign;
    logic [63:0] mag;
    logic [9:0]  e2;     // signed exponent offset
  } te2f_s1_t;

  // Stage 2 to stage 3: normalized magnitude (msb at bit 63).
  typedef struct packed {
    logic        done;
    logic [31:0] word;
    logic        sign;
    logic        zero;
    logic [63:0] norm;
    logic [9:0]  exp;    // biased exponent before rounding carry
  } te2f_s2_t;

endpackage

>>> sv/tensor_element_to_fp32_converter.sv
// Tensor element to binary32 converter.
// Slave channel: s_axis_tdata carries op and the raw element; each transfer
// is one element. Master channel: m_axis_tdata carries the binary32 pattern.
// Three register stages: decode, leading-one normalize, round and pack.
// An accepted element passes s1_q, s2_q and out_q in that order; out_q drives
// the master side.
// Throughput is one element per cycle while the receiver does not stall; the
// leading-one search and the 64-bit shift set the stage depth.
// Reset clears all valid bits; payload registers hold no reset value.
// When the receiver stalls, the output stage holds, empty earlier stages fill,
// and slave-side ready falls once the pipe is full; nothing is lost or repeated.
// Unused dtype codes give a zero result.
module tensor_element_to_fp32_converter
  import te2f_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // [3:0] op, [67:4] raw_element, rest zero
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // [31:0] fp32_bits
);

  te2f_s1_t dec_d, s1_q;
  te2f_s2_t s2_d, s2_q;
  logic [31:0] word_d, out_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // stall chain
  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  te2f_decode u_decode (
    .op_i  (s_axis_tdata[3:0]),
    .raw_i (s_axis_tdata[67:4]),
    .dec_o (dec_d)
  );

  te2f_norm u_norm (
    .s1_i (s1_q),
    .s2_o (s2_d)
  );

  te2f_round u_round (
    .s2_i   (s2_q),
    .word_o (word_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en1) s1_q  <= dec_d;
    if (en2) s2_q  <= s2_d;
    if (en3) out_q <= word_d;
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v1_q && v2_q && v3_q && !m_axis_tready) || !s_axis_tready)
    else $error("ready while pipe full and stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted item lost");
`endif

endmodule

>>> sv/te2f_decode.sv
module te2f_decode
  import te2f_pkg::*;
(
  input  logic [OpWidth-1:0]  op_i,
  input  logic [RawWidth-1:0] raw_i,
  output te2f_s1_t            dec_o
);

  always_comb begin
    dec_o = '0;
    unique case (op_i)
      OP_F32: begin
        dec_o.done = 1'b1;
        dec_o.word = raw_i[31:0];
      end
      OP_BF16: begin
        dec_o.done = 1'b1;
        dec_o.word = {raw_i[15:0], 16'h0};
      end
      OP_BOOL: begin
        dec_o.done = 1'b1;
        dec_o.word = (raw_i[7:0] != 8'h0) ? OneBits : 32'h0;
      end
      OP_F16: begin
        dec_o.sign = raw_i[15];
        if (raw_i[14:10] == 5'h1F) begin
          dec_o.done = 1'b1;
          dec_o.word = (raw_i[9:0] != 10'h0) ? QnanBits : (InfBits | {raw_i[15], 31'h0});
        end else if (raw_i[14:10] == 5'h0) begin
          dec_o.mag = {54'h0, raw_i[9:0]};
          dec_o.e2  = -10'sd24;
        end else begin
          dec_o.mag = {53'h0, 1'b1, raw_i[9:0]};
          dec_o.e2  = {5'h0, raw_i[14:10]} - 10'd25;
        end
      end
      OP_E5M2: begin
        dec_o.sign = raw_i[7];
        if (raw_i[6:2] == 5'h1F) begin
          dec_o.done = 1'b1;
          dec_o.word = (raw_i[1:0] != 2'h0) ? QnanBits : (InfBits | {raw_i[7], 31'h0});
        end else if (raw_i[6:2] == 5'h0) begin
          dec_o.mag = {62'h0, raw_i[1:0]};
          dec_o.e2  = -10'sd16;
        end else begin
          dec_o.mag = {61'h0, 1'b1, raw_i[1:0]};
          dec_o.e2  = {5'h0, raw_i[6:2]} - 10'd17;
        end
      end
      OP_E4M3: begin
        dec_o.sign = raw_i[7];
        if (raw_i[6:0] == 7'h7F) begin
          dec_o.done = 1'b1;
          dec_o.word = QnanBits;
        end else if (raw_i[6:3] == 4'h0) begin
          dec_o.mag = {61'h0, raw_i[2:0]};
          dec_o.e2  = -10'sd9;
        end else begin
          dec_o.mag = {60'h0, 1'b1, raw_i[2:0]};
          dec_o.e2  = {6'h0, raw_i[6:3]} - 10'd10;
        end
      end
      OP_I64: begin
        dec_o.sign = raw_i[63];
        dec_o.mag  = raw_i[63] ? (~raw_i + 64'd1) : raw_i;
      end
      OP_I32: begin
        dec_o.sign = raw_i[31];
        dec_o.mag  = {32'h0, raw_i[31] ? (~raw_i[31:0] + 32'd1) : raw_i[31:0]};
      end
      OP_I16: begin
        dec_o.sign = raw_i[15];
        dec_o.mag  = {48'h0, raw_i[15] ? (~raw_i[15:0] + 16'd1) : raw_i[15:0]};
      end
      OP_I8: begin
        dec_o.sign = raw_i[7];
        dec_o.mag  = {56'h0, raw_i[7] ? (~raw_i[7:0] + 8'd1) : raw_i[7:0]};
      end
      OP_U8: begin
        dec_o.mag = {56'h0, raw_i[7:0]};
      end
      default: begin
        dec_o.done = 1'b1;
      end
    endcase
  end

endmodule

>>> sv/te2f_norm.sv
module te2f_norm
  import te2f_pkg::*;
(
  input  te2f_s1_t s1_i,
  output te2f_s2_t s2_o
);

  logic [PosWidth-1:0] msb;
  logic [63:0]         shifted;

  // leading-one position
  always_comb begin
    msb = '0;
    for (int i = 0; i < 64; i++) begin
      if (s1_i.mag[i]) msb = PosWidth'(i);
    end
  end

  assign shifted = s1_i.mag << (6'd63 - msb);

  always_comb begin
    s2_o      = '0;
    s2_o.done = s1_i.done;
    s2_o.word = s1_i.word;
    s2_o.sign = s1_i.sign;
    s2_o.zero = (s1_i.mag == 64'h0);
    s2_o.norm = shifted;
    s2_o.exp  = {4'h0, msb} + s1_i.e2 + 10'd127;
  end

endmodule

>>> sv/te2f_round.sv
module te2f_round
  import te2f_pkg::*;
(
  input  te2f_s2_t             s2_i,
  output logic [Fp32Width-1:0] word_o
);

  logic        up;
  logic [24:0] mant;
  logic [9:0]  exp;

  // round to nearest even on bit 40
  always_comb begin
    up   = s2_i.norm[39] && ((s2_i.norm[38:0] != 39'h0) || s2_i.norm[40]);
    mant = {1'b0, s2_i.norm[63:40]} + {24'h0, up};
    exp  = s2_i.exp + {9'h0, mant[24]};
    if (s2_i.done) begin
      word_o = s2_i.word;
    end else if (s2_i.zero) begin
      word_o = {s2_i.sign, 31'h0};
    end else begin
      word_o = {s2_i.sign, exp[7:0], mant[24] ? mant[23:1] : mant[22:0]};
    end
  end

endmodule
